/* rtl/lup_pkg.sv */
`default_nettype none

package lup_pkg;

    localparam int SAMPLE_W = 16;
    // The interpolation numerator stays below 7 * 32768 in magnitude, even
    // one step past the last output, so 19 signed bits hold every value.
    localparam int NUM_W    = 19;
    localparam int DELTA_W  = SAMPLE_W + 1;
    localparam int PHASE_W  = 8;

    localparam logic [PHASE_W-1:0] CYCLE_LAST    = 8'd146;
    localparam logic [PHASE_W-1:0] EXTRA_PHASE_A = 8'd1;
    localparam logic [PHASE_W-1:0] EXTRA_PHASE_B = 8'd49;
    localparam logic [PHASE_W-1:0] EXTRA_PHASE_C = 8'd98;

    localparam logic [2:0] N_SHORT = 3'd4;
    localparam logic [2:0] N_LONG  = 3'd5;

    // floor(x / 5) == (x * 52429) >> 18 for every x below 2^18.
    localparam int          RECIP_SHIFT = 18;
    localparam logic [15:0] RECIP5      = 16'd52429;

    typedef struct packed {
        logic signed [NUM_W-1:0]   num;
        logic signed [DELTA_W-1:0] delta;
        logic                      n5;
    } lup_entry_t;

endpackage

`default_nettype wire

/* rtl/linear_upsampler_147_to_640_top.sv */
`default_nettype none

// Linear-interpolation upsampler, 147 inputs to 640 outputs (11025 Hz to
// 48 kHz). Each accepted mono Q15 sample produces four or five results, set by
// a phase counter that cycles over 147 inputs; each result carries the same
// value on left and right, and m_last_of_run marks the final one. Results
// leave one per cycle while m_ready is held high and samples keep arriving;
// the single result port bounds the rate. A two-entry queue sits
// between the input stage and the interpolator, so the next sample is taken
// while the current one is still being expanded. The first sample after
// reset interpolates from zero.
module linear_upsampler_147_to_640_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [lup_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [lup_pkg::SAMPLE_W-1:0]      m_left_out,
    output logic signed [lup_pkg::SAMPLE_W-1:0]      m_right_out,
    output logic                                     m_last_of_run
);
    import lup_pkg::*;

    lup_entry_t push_data;
    lup_entry_t pop_data;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    lup_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .q_full      (full),
        .q_push      (push),
        .q_push_data (push_data)
    );

    lup_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    lup_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (empty),
        .q_pop_data    (pop_data),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_out    (m_left_out),
        .m_right_out   (m_right_out),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

/* rtl/lup_front.sv */
`default_nettype none

module lup_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [lup_pkg::SAMPLE_W-1:0] s_sample_in,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output lup_pkg::lup_entry_t                  q_push_data
);
    import lup_pkg::*;

    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [1:0]                 mod3_reg, mod3_next;
    logic                       n5;
    logic signed [NUM_W-1:0]    prev_ext, curr_ext;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // The mod-3 counter runs beside the phase; 147 is a multiple of 3, so
    // both wrap together.
    always_comb begin
        n5 = (phase_reg == EXTRA_PHASE_A) || (phase_reg == EXTRA_PHASE_B) ||
             (phase_reg == EXTRA_PHASE_C) || (mod3_reg == 2'd0);
        prev_ext = NUM_W'(prev_reg);
        curr_ext = NUM_W'(s_sample_in);
        q_push_data.n5    = n5;
        q_push_data.delta = DELTA_W'(s_sample_in) - DELTA_W'(prev_reg);
        if (n5) begin
            q_push_data.num = (prev_ext <<< 2) + curr_ext;
        end else begin
            q_push_data.num = (prev_ext <<< 1) + prev_ext + curr_ext;
        end
    end

    always_comb begin
        prev_next  = prev_reg;
        phase_next = phase_reg;
        mod3_next  = mod3_reg;
        if (q_push) begin
            prev_next = s_sample_in;
            if (phase_reg >= CYCLE_LAST) begin
                phase_next = '0;
                mod3_next  = 2'd0;
            end else begin
                phase_next = phase_reg + 1'b1;
                mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            phase_reg <= '0;
            mod3_reg  <= '0;
        end else begin
            prev_reg  <= prev_next;
            phase_reg <= phase_next;
            mod3_reg  <= mod3_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lup_queue.sv */
`default_nettype none

module lup_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire lup_pkg::lup_entry_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output lup_pkg::lup_entry_t      pop_data,
    output logic                     empty
);
    import lup_pkg::*;

    lup_entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != 2'd2)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("pop from an empty queue");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

/* rtl/lup_back.sv */
`default_nettype none

module lup_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_empty,
    input  wire lup_pkg::lup_entry_t              q_pop_data,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [lup_pkg::SAMPLE_W-1:0]   m_left_out,
    output logic signed [lup_pkg::SAMPLE_W-1:0]   m_right_out,
    output logic                                  m_last_of_run
);
    import lup_pkg::*;

    logic                       active_reg, active_next;
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic signed [DELTA_W-1:0]  delta_reg, delta_next;
    logic                       n5_reg, n5_next;
    logic [2:0]                 k_reg, k_next;

    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;
    logic                       last_reg, last_next;

    logic                       issue;
    logic                       last;
    logic                       neg;
    logic signed [NUM_W-1:0]    num_rnd;
    logic signed [NUM_W-1:0]    num_neg;
    logic [NUM_W-2:0]           mag;
    logic [NUM_W-2+16:0]        prod;
    logic [SAMPLE_W-1:0]        q5;
    logic signed [SAMPLE_W-1:0] quotient;

    assign issue = active_reg && (!m_valid_reg || m_ready);
    assign last  = (k_reg == (n5_reg ? N_LONG : N_SHORT));
    assign q_pop = !q_empty && (!active_reg || (issue && last));

    // Division toward zero: by 4 with a bias on negative values, by 5 via
    // a reciprocal multiply on the magnitude.
    always_comb begin
        neg     = num_reg[NUM_W-1];
        num_rnd = num_reg + (neg ? NUM_W'(3) : NUM_W'(0));
        num_neg = -num_reg;
        mag     = neg ? num_neg[NUM_W-2:0] : num_reg[NUM_W-2:0];
        prod    = (NUM_W-1+16)'(mag) * (NUM_W-1+16)'(RECIP5);
        q5      = prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
        if (n5_reg) begin
            quotient = neg ? SAMPLE_W'(-q5) : q5;
        end else begin
            quotient = num_rnd[SAMPLE_W+1:2];
        end
    end

    always_comb begin
        active_next = active_reg;
        num_next    = num_reg;
        delta_next  = delta_reg;
        n5_next     = n5_reg;
        k_next      = k_reg;
        if (issue) begin
            num_next = num_reg + NUM_W'(delta_reg);
            k_next   = k_reg + 3'd1;
            if (last) begin
                active_next = 1'b0;
            end
        end
        if (q_pop) begin
            active_next = 1'b1;
            num_next    = q_pop_data.num;
            delta_next  = q_pop_data.delta;
            n5_next     = q_pop_data.n5;
            k_next      = 3'd1;
        end
    end

    always_comb begin
        out_next     = out_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (issue) begin
            out_next     = quotient;
            last_next    = last;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg   <= num_next;
        delta_reg <= delta_next;
        n5_reg    <= n5_next;
        out_reg   <= out_next;
        last_reg  <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_left_out    = out_reg;
    assign m_right_out   = out_reg;
    assign m_last_of_run = last_reg;

`ifndef SYNTHESIS
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (k_reg >= 3'd1) && (k_reg <= (n5_reg ? N_LONG : N_SHORT)))
        else $error("output index out of range");
    a_pop_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> active_reg && (k_reg == 3'd1))
        else $error("run did not start at the first output");
    a_mid_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && !last) |=> active_reg)
        else $error("run ended before its last output");
`endif

endmodule

`default_nettype wire
